### rtl/slmr_pkg.sv
// ----------------------------------------------------------------------------
// slmr_pkg: shared types and constants
// Field widths, command and status codes, and the control word that
// drives the row of list cells.
// ----------------------------------------------------------------------------
`default_nettype none

package slmr_pkg;

  localparam int VAL_W       = 16;
  localparam int SUM_W       = 22;
  localparam int IDX_W       = 6;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int CNT_OUT_W   = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD      = 3'd0,
    OP_INSERT    = 3'd1,
    OP_MARK_REM  = 3'd2,
    OP_MARK_READ = 3'd3,
    OP_REMOVE    = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [VAL_W-1:0]   val;
    logic signed [SUM_W-1:0]   mean;
    logic        [IDX_W-1:0]   index;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/slmr_cell.sv
// ----------------------------------------------------------------------------
// slmr_cell: one position of the sorted list
// Holds one entry, compares it against the broadcast operand and trades
// values with its neighbours to open or close a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module slmr_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire slmr_pkg::cell_ctrl_t             ctrl,
  input  wire [CW-1:0]                          count,
  input  wire [slmr_pkg::VAL_W-1:0]             prev_value,
  input  wire                                   prev_lt,
  input  wire                                   prev_gt,
  input  wire [slmr_pkg::VAL_W-1:0]             next_value,
  output logic [slmr_pkg::VAL_W-1:0]            value,
  output logic                                  lt,
  output logic                                  gt,
  output logic [slmr_pkg::VAL_W-1:0]            tap,
  output logic                                  hit
);

  logic [slmr_pkg::VAL_W-1:0] value_r, value_nxt;
  logic [slmr_pkg::VAL_W-1:0] tap_r, tap_nxt;
  logic                       hit_r, hit_nxt;
  logic                       occ;
  logic [slmr_pkg::SUM_W-1:0] value_ext;

  assign occ       = 32'(count) > IDX;
  assign value_ext = {{(slmr_pkg::SUM_W-slmr_pkg::VAL_W){value_r[slmr_pkg::VAL_W-1]}},
                      value_r};
  assign lt        = occ && ($signed(value_r) < $signed(ctrl.val));
  assign gt        = occ && ($signed(value_ext) > $signed(ctrl.mean));

  always_comb begin
    value_nxt = value_r;
    hit_nxt   = 1'b0;
    case (ctrl.op)
      slmr_pkg::OP_INSERT: begin
        // keep smaller entries, take the new value at the gap, shift the rest up
        if (lt) begin
          value_nxt = value_r;
        end else if (prev_lt) begin
          value_nxt = ctrl.val;
        end else begin
          value_nxt = prev_value;
        end
      end
      slmr_pkg::OP_REMOVE: begin
        if (gt) begin
          value_nxt = next_value;
        end
      end
      slmr_pkg::OP_MARK_REM: begin
        hit_nxt = gt && !prev_gt;
      end
      slmr_pkg::OP_MARK_READ: begin
        hit_nxt = occ && (32'(ctrl.index) == IDX);
      end
      default: begin
        value_nxt = value_r;
      end
    endcase
    tap_nxt = hit_nxt ? value_r : '0;
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    tap_r   <= tap_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign value = value_r;
  assign tap   = tap_r;
  assign hit   = hit_r;

endmodule

`default_nettype wire

### rtl/slmr_div.sv
// ----------------------------------------------------------------------------
// slmr_div: floor division of the running sum by the count
// Restoring divider on the magnitude, one quotient bit per cycle, with a
// rounding fix towards minus infinity for negative sums.
// ----------------------------------------------------------------------------
`default_nettype none

module slmr_div #(
  parameter int CW = 7
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  input  wire [slmr_pkg::SUM_W-1:0]             num,
  input  wire [CW-1:0]                          den,
  output logic                                  done,
  output logic [slmr_pkg::SUM_W-1:0]            mean
);

  localparam int STEP_W = $clog2(slmr_pkg::SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(slmr_pkg::SUM_W - 1);

  logic [slmr_pkg::SUM_W-1:0] mag_r, mag_nxt;
  logic [CW-1:0]              rem_r, rem_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic                       neg_r, neg_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CW:0]                rem_sh;
  logic                       ge;

  assign rem_sh = {rem_r, mag_r[slmr_pkg::SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_comb begin
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      neg_nxt  = num[slmr_pkg::SUM_W-1];
      mag_nxt  = num[slmr_pkg::SUM_W-1] ? (~num + 1'b1) : num;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? CW'(rem_sh - {1'b0, den}) : rem_sh[CW-1:0];
      mag_nxt  = {mag_r[slmr_pkg::SUM_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // -q rounds up for a negative sum; floor needs one less when inexact
  assign mean = !neg_r ? mag_r : ((rem_r != '0) ? ~mag_r : (~mag_r + 1'b1));
  assign done = done_r;

endmodule

`default_nettype wire

### rtl/sorted_list_mean_remove_unit.sv
// Insert, read, unknown commands and remove on an empty list pass through
// S_EXEC, S_COLLECT and S_DONE before out_tvalid rises; remove on a non-empty
// list first waits in S_DIV for the one-bit-per-cycle divider that forms the
// mean. One command at a time; the next is taken once the current one has left
// for the output register, which waits on out_tready while the output is held.
// Reset empties the list (count and sum zero).
// ----------------------------------------------------------------------------
// sorted_list_mean_remove_unit: sorted list with mean-based removal
// A row of cells keeps the entries in ascending order; a command sequencer
// broadcasts insert, remove and read operations across the row.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_mean_remove_unit #(
  parameter int CAPACITY = 64
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  // [1:0] command, [17:2] value, [23:18] index
  input  wire [slmr_pkg::IN_TDATA_W-1:0]        in_tdata,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  // [1:0] status, [17:2] data_value, [24:18] count, [46:25] total
  output logic [slmr_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_DIV     = 5'b00010,
    S_EXEC    = 5'b00100,
    S_COLLECT = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t                             state_r, state_nxt;
  logic [slmr_pkg::CMD_W-1:0]         cmd_r, cmd_nxt;
  logic [slmr_pkg::VAL_W-1:0]         val_r, val_nxt;
  logic [slmr_pkg::IDX_W-1:0]         idx_r, idx_nxt;
  logic [slmr_pkg::SUM_W-1:0]         mean_r, mean_nxt;
  logic [CW-1:0]                      cnt_r, cnt_nxt;
  logic [slmr_pkg::SUM_W-1:0]         sum_r, sum_nxt;
  logic                               full_r, full_nxt;
  logic [slmr_pkg::STATUS_W-1:0]      status_r, status_nxt;
  logic [slmr_pkg::VAL_W-1:0]         data_r, data_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [slmr_pkg::OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;

  slmr_pkg::cell_ctrl_t               ctrl;
  logic                               div_start;
  logic                               div_done;
  logic [slmr_pkg::SUM_W-1:0]         div_mean;

  logic [slmr_pkg::VAL_W-1:0]         value_w [CAPACITY];
  logic [slmr_pkg::VAL_W-1:0]         tap_w   [CAPACITY];
  logic [CAPACITY-1:0]                lt_w, gt_w, hit_w;
  logic [slmr_pkg::VAL_W-1:0]         tap_or;
  logic                               found;
  logic [slmr_pkg::SUM_W-1:0]         val_ext, data_ext;
  logic                               in_xact;
  logic                               out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_xact   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign val_ext  = {{(slmr_pkg::SUM_W-slmr_pkg::VAL_W){val_r[slmr_pkg::VAL_W-1]}}, val_r};
  assign data_ext = {{(slmr_pkg::SUM_W-slmr_pkg::VAL_W){tap_or[slmr_pkg::VAL_W-1]}}, tap_or};

  // collect the marked cell: at most one tap is non-zero
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | tap_w[i];
    end
  end
  assign found = |hit_w;

  slmr_div #(.CW(CW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_r),
    .den   (cnt_r),
    .done  (div_done),
    .mean  (div_mean)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [slmr_pkg::VAL_W-1:0] prev_value;
    logic                       prev_lt;
    logic                       prev_gt;
    logic [slmr_pkg::VAL_W-1:0] next_value;

    if (g == 0) begin : g_head
      assign prev_value = ctrl.val;
      assign prev_lt    = 1'b1;
      assign prev_gt    = 1'b0;
    end else begin : g_body
      assign prev_value = value_w[g-1];
      assign prev_lt    = lt_w[g-1];
      assign prev_gt    = gt_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign next_value = value_w[g];
    end else begin : g_inner
      assign next_value = value_w[g+1];
    end

    slmr_cell #(.IDX(g), .CW(CW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .count      (cnt_r),
      .prev_value (prev_value),
      .prev_lt    (prev_lt),
      .prev_gt    (prev_gt),
      .next_value (next_value),
      .value      (value_w[g]),
      .lt         (lt_w[g]),
      .gt         (gt_w[g]),
      .tap        (tap_w[g]),
      .hit        (hit_w[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    mean_nxt      = mean_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    full_nxt      = full_r;
    status_nxt    = status_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    ctrl.op       = slmr_pkg::OP_HOLD;
    ctrl.val      = val_r;
    ctrl.mean     = mean_r;
    ctrl.index    = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_xact) begin
          cmd_nxt = in_tdata[1:0];
          val_nxt = in_tdata[17:2];
          idx_nxt = in_tdata[23:18];
          if (in_tdata[1:0] == slmr_pkg::CMD_REMOVE && cnt_r != '0) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          mean_nxt  = div_mean;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        full_nxt = 1'b0;
        case (cmd_r)
          slmr_pkg::CMD_INSERT: begin
            if (cnt_r >= CAP_C) begin
              full_nxt = 1'b1;
            end else begin
              ctrl.op = slmr_pkg::OP_INSERT;
              cnt_nxt = cnt_r + 1'b1;
              sum_nxt = sum_r + val_ext;
            end
          end
          slmr_pkg::CMD_REMOVE: begin
            if (cnt_r != '0) begin
              ctrl.op = slmr_pkg::OP_MARK_REM;
            end
          end
          slmr_pkg::CMD_READ: begin
            ctrl.op = slmr_pkg::OP_MARK_READ;
          end
          default: begin
            ctrl.op = slmr_pkg::OP_HOLD;
          end
        endcase
        state_nxt = S_COLLECT;
      end
      S_COLLECT: begin
        data_nxt = tap_or;
        case (cmd_r)
          slmr_pkg::CMD_INSERT: begin
            status_nxt = full_r ? slmr_pkg::ST_FULL : slmr_pkg::ST_OK;
          end
          slmr_pkg::CMD_REMOVE: begin
            if (found) begin
              // close the gap above the removed entry
              ctrl.op    = slmr_pkg::OP_REMOVE;
              cnt_nxt    = cnt_r - 1'b1;
              sum_nxt    = sum_r - data_ext;
              status_nxt = slmr_pkg::ST_OK;
            end else begin
              status_nxt = slmr_pkg::ST_NONE;
            end
          end
          slmr_pkg::CMD_READ: begin
            status_nxt = found ? slmr_pkg::ST_OK : slmr_pkg::ST_RANGE;
          end
          default: begin
            status_nxt = slmr_pkg::ST_OK;
          end
        endcase
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, sum_r, slmr_pkg::CNT_OUT_W'(cnt_r), data_r, status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    mean_r     <= mean_nxt;
    full_r     <= full_nxt;
    status_r   <= status_nxt;
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C)
    else $error("entry count above capacity");

  a_single_hit : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COLLECT |-> $onehot0(hit_w))
    else $error("more than one cell marked");

  a_div_done_state : assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside division state");

  a_cnt_change : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != $past(cnt_r) |-> ($past(state_r) == S_EXEC || $past(state_r) == S_COLLECT))
    else $error("count changed outside an update state");

  a_sum_follows_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 && $past(cnt_r) != '0 |-> sum_r == '0)
    else $error("sum not zero on an emptied list");

endmodule

`default_nettype wire
